// ===== hw/rtl/qpsa_pkg.sv =====
// shared types, codes and defaults for the queue pair slot allocator
package qpsa_pkg;

   localparam int SLOT_COUNT_DEF = 64;
   localparam int ID_BITS_DEF = 12;

   localparam logic [1:0] OP_ASSIGN = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_CLEANUP = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_OWNER = 2'd2;
   localparam logic [1:0] ST_NOT_ATTACHED = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] requester_id;
      logic        attached;
      logic [5:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_slot;
      logic [6:0] freed_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic grant;
      logic set_full;
      logic lookup_done;
      logic sel_sweep;
      logic sweep_issue;
      logic sweep_cmp;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       req_attached;
      logic       slot_free;
      logic       scan_last;
      logic       sweep_last;
      logic       out_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/qpsa_ctrl.sv =====
// controller state machine for the queue pair slot allocator
module qpsa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  qpsa_pkg::dp_stat_type    stat,
   output qpsa_pkg::ctrl_cmd_type   cmd
);
   import qpsa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LOOK = 3'd2;
   localparam logic [2:0] S_CMP = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (stat.req_op)
                  OP_ASSIGN: state_in = stat.req_attached ? S_SCAN : S_EMIT;
                  OP_RELEASE: state_in = S_LOOK;
                  OP_CHECK: state_in = stat.req_attached ? S_LOOK : S_EMIT;
                  default: state_in = S_SWEEP;
               endcase
            end
         end
         S_SCAN: begin
            if (stat.slot_free) begin
               cmd.grant = 1'b1;
               state_in = S_EMIT;
            end else if (stat.scan_last) begin
               cmd.set_full = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_LOOK: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.lookup_done = 1'b1;
            state_in = S_EMIT;
         end
         S_SWEEP: begin
            cmd.sel_sweep = 1'b1;
            cmd.sweep_issue = 1'b1;
            cmd.sweep_cmp = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.sel_sweep = 1'b1;
            cmd.sweep_cmp = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/qpsa_dp.sv =====
// datapath of the queue pair slot allocator: slot table, owner memory, result register
module qpsa_dp #(
   parameter int SLOT_COUNT = qpsa_pkg::SLOT_COUNT_DEF,
   parameter int ID_BITS = qpsa_pkg::ID_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qpsa_pkg::req_type        req_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output qpsa_pkg::rsp_type        rsp_data,
   input  qpsa_pkg::ctrl_cmd_type   cmd,
   output qpsa_pkg::dp_stat_type    stat
);
   import qpsa_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   logic [ID_BITS-1:0] owner_mem [SLOT_COUNT];

   logic [1:0]            op_ff, op_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [5:0]            slot_index_ff, slot_index_in;
   logic [1:0]            status_ff, status_in;
   logic [IDX_W-1:0]      granted_ff, granted_in;
   logic [CNT_W-1:0]      freed_ff, freed_in;
   logic [IDX_W-1:0]      search_ptr_ff, search_ptr_in;
   logic [IDX_W-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [IDX_W-1:0]      sweep_addr_ff, sweep_addr_in;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [ID_BITS-1:0]    rd_owner_ff;
   logic                  rd_use_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rd_live_ff, rd_live_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0] slot_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             slot_ok;
   logic             hit;

   assign slot_addr = IDX_W'(slot_index_ff);
   assign slot_ok = (int'(slot_index_ff) < SLOT_COUNT);
   assign rd_addr = cmd.sel_sweep ? sweep_addr_ff : slot_addr;
   assign hit = rd_use_ff && (rd_owner_ff == id_ff);

   assign stat.req_op = req_data.operation;
   assign stat.req_attached = req_data.attached;
   assign stat.slot_free = !in_use_ff[scan_ptr_ff];
   assign stat.scan_last = (scan_cnt_ff == LAST_IDX);
   assign stat.sweep_last = (sweep_addr_ff == LAST_IDX);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      op_in = op_ff;
      id_in = id_ff;
      slot_index_in = slot_index_ff;
      status_in = status_ff;
      granted_in = granted_ff;
      freed_in = freed_ff;
      search_ptr_in = search_ptr_ff;
      scan_ptr_in = scan_ptr_ff;
      scan_cnt_in = scan_cnt_ff;
      sweep_addr_in = sweep_addr_ff;
      in_use_in = in_use_ff;
      rd_live_in = cmd.sweep_issue;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (cmd.load) begin
         op_in = req_data.operation;
         id_in = ID_BITS'(req_data.requester_id);
         slot_index_in = req_data.slot_index;
         if (((req_data.operation == OP_ASSIGN) || (req_data.operation == OP_CHECK))
             && !req_data.attached) begin
            status_in = ST_NOT_ATTACHED;
         end else begin
            status_in = ST_OK;
         end
         granted_in = '0;
         freed_in = '0;
         scan_ptr_in = search_ptr_ff;
         scan_cnt_in = '0;
         sweep_addr_in = '0;
      end

      if (cmd.scan_step) begin
         scan_ptr_in = (scan_ptr_ff == LAST_IDX) ? '0 : scan_ptr_ff + 1'b1;
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end

      if (cmd.grant) begin
         in_use_in[scan_ptr_ff] = 1'b1;
         granted_in = scan_ptr_ff;
         search_ptr_in = (scan_ptr_ff == LAST_IDX) ? '0 : scan_ptr_ff + 1'b1;
      end

      if (cmd.set_full) begin
         status_in = ST_FULL;
      end

      if (cmd.lookup_done) begin
         if (hit && slot_ok) begin
            if (op_ff == OP_RELEASE) begin
               in_use_in[rd_idx_ff] = 1'b0;
               freed_in = CNT_W'(1);
            end
         end else begin
            status_in = ST_NOT_OWNER;
         end
      end

      if (cmd.sweep_issue) begin
         sweep_addr_in = (sweep_addr_ff == LAST_IDX) ? '0 : sweep_addr_ff + 1'b1;
      end

      if (cmd.sweep_cmp && rd_live_ff && hit) begin
         in_use_in[rd_idx_ff] = 1'b0;
         freed_in = CNT_W'(freed_ff + 1'b1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.status = status_ff;
         rsp_data_in.granted_slot = 6'(granted_ff);
         rsp_data_in.freed_count = 7'(freed_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // owner table with registered read
   always_ff @(posedge clock) begin
      if (cmd.grant) begin
         owner_mem[scan_ptr_ff] <= id_ff;
      end
      rd_owner_ff <= owner_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      slot_index_ff <= slot_index_in;
      status_ff <= status_in;
      granted_ff <= granted_in;
      freed_ff <= freed_in;
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
      sweep_addr_ff <= sweep_addr_in;
      rd_use_ff <= in_use_ff[rd_addr];
      rd_idx_ff <= rd_addr;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         search_ptr_ff <= '0;
         rd_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_use_ff <= in_use_in;
         search_ptr_ff <= search_ptr_in;
         rd_live_ff <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/queue_pair_slot_allocator.sv =====
// top level of the queue pair slot allocator
//
// req channel: one transaction per command (assign, release, check_owner, cleanup),
// carrying the requester id, its attached bit and a slot index. rsp channel: one
// transaction per command with status, granted slot and freed count.
// One command is worked on at a time; req_ready is high only while the block is idle.
// Work from request to response:
//   assign: probes the in-use bits from the search pointer, up to SLOT_COUNT slots
//   release and check_owner: one owner memory read and compare
//   assign or check_owner without attachment: goes straight to the response
//   cleanup: one owner memory read per slot
// The probe of the in-use bits and the cleanup sweep through the owner memory each
// run one slot per cycle.
// A finished response sits in an output register; the next request is accepted while
// it waits, and that request's work stalls at its end until rsp_ready frees the register.
// Reset marks every slot free, clears the search pointer and drops rsp_valid.
module queue_pair_slot_allocator #(
   parameter int SLOT_COUNT = qpsa_pkg::SLOT_COUNT_DEF,
   parameter int ID_BITS = qpsa_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qpsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qpsa_pkg::rsp_type rsp_data
);
   import qpsa_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   qpsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   qpsa_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command was in progress");

   a_grant_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> stat.slot_free)
      else $error("assign granted a slot that is in use");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response overwritten before it was taken");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
         (rsp_data.granted_slot == 6'd0) && (rsp_data.freed_count == 7'd0))
      else $error("failed command reported a slot or a freed count");
`endif

endmodule

// ===== verif/queue_pair_slot_allocator_tb.sv =====
// self-checking testbench for the queue pair slot allocator
`timescale 1ns / 100ps

module queue_pair_slot_allocator_tb;
   import qpsa_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;
   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_CYCLES = SLOTS + 16;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_type;

   typedef struct packed {
      req_type cmd;
      rsp_type rsp;
   } expected_entry_type;

   typedef struct packed {
      req_type cmd;
      logic    fixed;
      rsp_type rsp;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic             slot_busy [SLOTS];
   logic [11:0]      slot_holder [SLOTS];
   logic [5:0]       search_ptr;
   expected_entry_type pending [$];
   directed_row_type directed_rows [$];

   logic [11:0] id_pool [4];
   int          pool_size = 1;
   bit          steady = 1'b0;
   int          stall_left = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   queue_pair_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_response(input req_type cmd);
      rsp_type    result;
      logic [5:0] probe;
      logic       found;
      result = '0;
      result.status = ST_OK;
      found = 1'b0;
      probe = '0;
      case (cmd.operation)
         OP_ASSIGN: begin
            if (!cmd.attached) begin
               result.status = ST_NOT_ATTACHED;
            end else begin
               for (int n = 0; n < SLOTS; n++) begin
                  if (!found && !slot_busy[6'(search_ptr + n)]) begin
                     found = 1'b1;
                     probe = 6'(search_ptr + n);
                  end
               end
               if (found) begin
                  slot_busy[probe] = 1'b1;
                  slot_holder[probe] = cmd.requester_id;
                  result.granted_slot = probe;
                  search_ptr = probe + 6'd1;
               end else begin
                  result.status = ST_FULL;
               end
            end
         end
         OP_RELEASE: begin
            if (slot_busy[cmd.slot_index] &&
                slot_holder[cmd.slot_index] == cmd.requester_id) begin
               slot_busy[cmd.slot_index] = 1'b0;
               result.freed_count = 7'd1;
            end else begin
               result.status = ST_NOT_OWNER;
            end
         end
         OP_CHECK: begin
            if (!cmd.attached) begin
               result.status = ST_NOT_ATTACHED;
            end else if (!(slot_busy[cmd.slot_index] &&
                           slot_holder[cmd.slot_index] == cmd.requester_id)) begin
               result.status = ST_NOT_OWNER;
            end
         end
         default: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (slot_busy[s] && slot_holder[s] == cmd.requester_id) begin
                  slot_busy[s] = 1'b0;
                  result.freed_count = result.freed_count + 7'd1;
               end
            end
         end
      endcase
      return result;
   endfunction

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic int pick_held_slot();
      int held [$];
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_busy[s]) held.push_back(s);
      end
      if (held.size() == 0) return -1;
      return held[$urandom_range(0, held.size() - 1)];
   endfunction

   function automatic directed_row_type make_row(input logic [1:0] op, input logic [11:0] id,
                                                 input logic att, input logic [5:0] slot,
                                                 input logic fixed, input logic [1:0] st,
                                                 input logic [5:0] granted,
                                                 input logic [6:0] freed);
      directed_row_type row;
      row.cmd.operation = op;
      row.cmd.requester_id = id;
      row.cmd.attached = att;
      row.cmd.slot_index = slot;
      row.fixed = fixed;
      row.rsp.status = st;
      row.rsp.granted_slot = granted;
      row.rsp.freed_count = freed;
      return row;
   endfunction

   function automatic void refresh_id_pool();
      int pick;
      pool_size = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) id_pool[k] = 12'h000;
         else if (pick == 1) id_pool[k] = 12'hFFF;
         else id_pool[k] = 12'($urandom);
      end
   endfunction

   function automatic req_type random_request(input traffic_mode_type mode);
      req_type cmd;
      int      roll;
      int      held;
      cmd = 21'($urandom);
      if ($urandom_range(0, 99) < 8) return cmd;
      roll = $urandom_range(0, 99);
      cmd.requester_id = id_pool[$urandom_range(0, pool_size - 1)];
      cmd.attached = ($urandom_range(0, 9) != 0);
      case (mode)
         MODE_FILL: begin
            if (roll < 85) cmd.operation = OP_ASSIGN;
            else if (roll < 90) cmd.operation = OP_RELEASE;
            else if (roll < 97) cmd.operation = OP_CHECK;
            else cmd.operation = OP_CLEANUP;
         end
         MODE_MIXED: begin
            if (roll < 35) cmd.operation = OP_ASSIGN;
            else if (roll < 65) cmd.operation = OP_RELEASE;
            else if (roll < 90) cmd.operation = OP_CHECK;
            else cmd.operation = OP_CLEANUP;
         end
         default: begin
            if (roll < 10) cmd.operation = OP_ASSIGN;
            else if (roll < 65) cmd.operation = OP_RELEASE;
            else if (roll < 88) cmd.operation = OP_CHECK;
            else cmd.operation = OP_CLEANUP;
         end
      endcase
      if (cmd.operation == OP_RELEASE || cmd.operation == OP_CHECK) begin
         held = pick_held_slot();
         if (held >= 0 && $urandom_range(0, 99) < 85) begin
            cmd.slot_index = 6'(held);
            cmd.requester_id = slot_holder[held];
         end
         if (cmd.operation == OP_RELEASE) cmd.attached = 1'($urandom);
      end else if (cmd.operation == OP_CLEANUP) begin
         cmd.attached = 1'($urandom);
         if ($urandom_range(0, 99) < 15) cmd.requester_id = 12'($urandom);
      end
      return cmd;
   endfunction

   task automatic send_request(input req_type cmd, input logic fixed, input rsp_type fixed_rsp);
      expected_entry_type entry;
      int                 gap;
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (!req_ready);
      entry.cmd = cmd;
      entry.rsp = predict_response(cmd);
      if (fixed) entry.rsp = fixed_rsp;
      pending.push_back(entry);
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         stall_left <= idle_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      expected_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected transaction: status %0d slot %0d freed %0d",
                        rsp_data.status, rsp_data.granted_slot, rsp_data.freed_count);
            end
         end else begin
            want = pending.pop_front();
            if (rsp_data.status !== want.rsp.status ||
                rsp_data.granted_slot !== want.rsp.granted_slot ||
                rsp_data.freed_count !== want.rsp.freed_count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch op %0d id %h att %0d slot %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           want.cmd.operation, want.cmd.requester_id, want.cmd.attached,
                           want.cmd.slot_index, want.rsp.status, want.rsp.granted_slot,
                           want.rsp.freed_count, rsp_data.status, rsp_data.granted_slot,
                           rsp_data.freed_count);
               end
            end
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("queue_pair_slot_allocator_tb NOT OK");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      req_type          cmd;
      traffic_mode_type mode;
      int               sent;
      int               phase_len;
      int               roll;

      for (int s = 0; s < SLOTS; s++) begin
         slot_busy[s] = 1'b0;
         slot_holder[s] = '0;
      end
      search_ptr = '0;

      // fresh table: free slot checks, detached requests, empty cleanup, first grants, owner checks, releases
      directed_rows.push_back(make_row(OP_CHECK, 12'h000, 1'b1, 6'd0, 1'b1, ST_NOT_OWNER, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'h5A5, 1'b0, 6'd0, 1'b1, ST_NOT_ATTACHED, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CHECK, 12'h000, 1'b0, 6'd63, 1'b1, ST_NOT_ATTACHED, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_RELEASE, 12'hFFF, 1'b1, 6'd63, 1'b1, ST_NOT_OWNER, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CLEANUP, 12'h000, 1'b0, 6'd0, 1'b1, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'hFFF, 1'b1, 6'd63, 1'b1, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'h000, 1'b1, 6'd0, 1'b1, ST_OK, 6'd1, 7'd0));
      directed_rows.push_back(make_row(OP_CHECK, 12'hFFF, 1'b1, 6'd0, 1'b1, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CHECK, 12'h000, 1'b1, 6'd0, 1'b1, ST_NOT_OWNER, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_RELEASE, 12'h000, 1'b1, 6'd0, 1'b1, ST_NOT_OWNER, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_RELEASE, 12'hFFF, 1'b0, 6'd0, 1'b1, ST_OK, 6'd0, 7'd1));
      // pointer keeps moving past freed slots; cleanups free each owner's slots
      directed_rows.push_back(make_row(OP_ASSIGN, 12'hAAA, 1'b1, 6'd42, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'h555, 1'b1, 6'd21, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CHECK, 12'h555, 1'b1, 6'd3, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_RELEASE, 12'h555, 1'b1, 6'd3, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'h555, 1'b1, 6'd0, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_ASSIGN, 12'h555, 1'b1, 6'd0, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CLEANUP, 12'h555, 1'b1, 6'd0, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CLEANUP, 12'h000, 1'b1, 6'd0, 1'b0, ST_OK, 6'd0, 7'd0));
      directed_rows.push_back(make_row(OP_CLEANUP, 12'hAAA, 1'b0, 6'd0, 1'b0, ST_OK, 6'd0, 7'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         send_request(row.cmd, row.fixed, row.rsp);
      end
      wait_for_drain();

      // one owner takes the whole table, overflows it, then frees all at once
      refresh_id_pool();
      pool_size = 1;
      repeat (SLOTS + 2) begin
         cmd = 21'($urandom);
         cmd.operation = OP_ASSIGN;
         cmd.requester_id = id_pool[0];
         cmd.attached = 1'b1;
         send_request(cmd, 1'b0, '0);
      end
      cmd.operation = OP_CLEANUP;
      send_request(cmd, 1'b0, '0);
      sent = SLOTS + 3;

      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) mode = MODE_FILL;
         else if (roll < 75) mode = MODE_MIXED;
         else mode = MODE_DRAIN;
         phase_len = $urandom_range(20, 100);
         refresh_id_pool();
         if ($urandom_range(0, 99) < 30) wait_for_drain();
         steady = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            send_request(random_request(mode), 1'b0, '0);
            sent++;
         end
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending.size() == 0) begin
         $display("queue_pair_slot_allocator_tb OK");
      end else begin
         $display("queue_pair_slot_allocator_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/qpsa_pkg.sv
hw/rtl/qpsa_ctrl.sv
hw/rtl/qpsa_dp.sv
hw/rtl/queue_pair_slot_allocator.sv
verif/queue_pair_slot_allocator_tb.sv
